// ===== hw/rtl/ll1pp_pkg.sv =====
package ll1pp_pkg;

    // Grammar and storage dimensions
    localparam int SYMBOL_BITS = 7;
    localparam int PRODUCTIONS = 32;
    localparam int MAX_BODY    = 8;
    localparam int STACK_DEPTH = 64;
    localparam int MAX_STEPS   = 63;

    // Fixed field widths of the channels
    localparam int OP_W         = 3;
    localparam int PROD_FIELD_W = 5;
    localparam int POS_W        = 4;
    localparam int ACT_W        = 3;
    localparam int SYM_W        = SYMBOL_BITS;

    // Derived storage geometry
    localparam int SYM_COUNT  = 1 << SYMBOL_BITS;
    localparam int TBL_DEPTH  = SYM_COUNT * SYM_COUNT;
    localparam int TBL_AW     = 2 * SYMBOL_BITS;
    localparam int PROD_W     = $clog2(PRODUCTIONS);
    localparam int BODY_DEPTH = PRODUCTIONS * MAX_BODY;
    localparam int BODY_AW    = $clog2(BODY_DEPTH);
    localparam int LEN_W      = $clog2(MAX_BODY + 1);
    localparam int STK_AW     = $clog2(STACK_DEPTH);
    localparam int SP_W       = $clog2(STACK_DEPTH + 1);
    localparam int STEP_W     = $clog2(MAX_STEPS + 1);

    localparam logic [SYM_W-1:0] END_MARK    = SYM_W'(8'h24);  // '$'
    localparam logic [SYM_W-1:0] LAMBDA_MARK = SYM_W'(8'h5E);  // '^'
    localparam logic [SYM_W-1:0] START_RESET = SYM_W'(8'h53);  // 'S'

    typedef enum logic [OP_W-1:0] {
        OP_TABLE  = 3'd0,
        OP_BODY   = 3'd1,
        OP_LENGTH = 3'd2,
        OP_BEGIN  = 3'd3,
        OP_TOKEN  = 3'd4
    } op_t;

    typedef enum logic [ACT_W-1:0] {
        ACT_ACK    = 3'd0,
        ACT_EXPAND = 3'd1,
        ACT_MATCH  = 3'd2,
        ACT_ACCEPT = 3'd3,
        ACT_REJECT = 3'd4
    } act_t;

    typedef enum logic [1:0] {
        SSEL_ZERO  = 2'd0,
        SSEL_TOP   = 2'd1,
        SSEL_START = 2'd2
    } sym_sel_t;

    typedef struct packed {
        logic     take;        // latch the input item
        logic     clr_step;    // clear one table entry and advance
        logic     tbl_wr;
        logic     body_wr;
        logic     len_wr;
        logic     begin_base;  // write end marker at the stack bottom
        logic     begin_top;   // write start symbol, arm the parser
        logic     tok_start;   // zero the expansion count
        logic     stk_rd;
        logic     tbl_rd;
        logic     entry_rd;    // read body length and first body symbol
        logic     pop_setup;   // pop the nonterminal, load push count
        logic     push;
        logic     pop_match;
        logic     step_inc;
        logic     deactivate;
        logic     emit;
        act_t     act;
        sym_sel_t sym_sel;
        logic     prod_sel;
        logic     last;
    } dp_cmd_t;

    typedef struct packed {
        logic clr_last;
        op_t  op;
        logic active;
        logic sp_zero;
        logic top_eq_tok;
        logic tok_is_end;
        logic entry_valid;
        logic steps_max;
        logic overflow;
        logic len_zero;
        logic cnt_last;
        logic slot_free;
    } dp_status_t;

endpackage

// ===== hw/rtl/ll1pp_item_if.sv =====
interface ll1pp_item_if;
    import ll1pp_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [OP_W-1:0]         operation;
    logic [SYM_W-1:0]        nonterminal;
    logic [SYM_W-1:0]        terminal;
    logic [PROD_FIELD_W-1:0] production;
    logic [POS_W-1:0]        position;
    logic [SYM_W-1:0]        symbol;

    modport source (
        output valid, operation, nonterminal, terminal, production, position, symbol,
        input  ready
    );

    modport sink (
        input  valid, operation, nonterminal, terminal, production, position, symbol,
        output ready
    );
endinterface

// ===== hw/rtl/ll1pp_result_if.sv =====
interface ll1pp_result_if;
    import ll1pp_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [ACT_W-1:0]        action;
    logic [PROD_FIELD_W-1:0] production_used;
    logic [SYM_W-1:0]        stack_symbol;
    logic                    last;

    modport source (
        output valid, action, production_used, stack_symbol, last,
        input  ready
    );

    modport sink (
        input  valid, action, production_used, stack_symbol, last,
        output ready
    );
endinterface

// ===== hw/rtl/ll1pp_datapath.sv =====
module ll1pp_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [ll1pp_pkg::SYM_W-1:0]        cfg_wr_data,
    input  logic [ll1pp_pkg::OP_W-1:0]         in_operation,
    input  logic [ll1pp_pkg::SYM_W-1:0]        in_nonterminal,
    input  logic [ll1pp_pkg::SYM_W-1:0]        in_terminal,
    input  logic [ll1pp_pkg::PROD_FIELD_W-1:0] in_production,
    input  logic [ll1pp_pkg::POS_W-1:0]        in_position,
    input  logic [ll1pp_pkg::SYM_W-1:0]        in_symbol,
    input  ll1pp_pkg::dp_cmd_t                 cmd,
    output ll1pp_pkg::dp_status_t              status,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [ll1pp_pkg::ACT_W-1:0]        out_action,
    output logic [ll1pp_pkg::PROD_FIELD_W-1:0] out_production_used,
    output logic [ll1pp_pkg::SYM_W-1:0]        out_stack_symbol,
    output logic                              out_last
);
    import ll1pp_pkg::*;

    // Latched input item
    logic [OP_W-1:0]         op_reg;
    logic [SYM_W-1:0]        nt_reg;
    logic [SYM_W-1:0]        t_reg;
    logic [PROD_FIELD_W-1:0] prod_reg;
    logic [POS_W-1:0]        pos_reg;
    logic [SYM_W-1:0]        sym_reg;

    // Control state
    logic [SYM_W-1:0]  start_reg;
    logic [SP_W-1:0]   sp_reg;
    logic [SP_W-1:0]   sp_next;
    logic              active_reg;
    logic [STEP_W-1:0] steps_reg;
    logic [LEN_W-1:0]  cnt_reg;
    logic [TBL_AW-1:0] clr_reg;

    // Memories and their registered read data
    logic [PROD_W:0]    tbl_mem [TBL_DEPTH];
    logic [PROD_W:0]    tbl_rdata_reg;
    logic [SYM_W-1:0]   body_mem [BODY_DEPTH];
    logic [SYM_W-1:0]   body_rdata_reg;
    logic [LEN_W-1:0]   len_mem [PRODUCTIONS];
    logic [LEN_W-1:0]   len_rdata_reg;
    logic [SYM_W-1:0]   stk_mem [STACK_DEPTH];
    logic [SYM_W-1:0]   stk_rdata_reg;

    // Output register
    logic                    out_valid_reg;
    logic [ACT_W-1:0]        out_act_reg;
    logic [PROD_FIELD_W-1:0] out_prod_reg;
    logic [SYM_W-1:0]        out_sym_reg;
    logic                    out_last_reg;

    logic              prod_ok;
    logic              pos_ok;
    logic [PROD_W-1:0] entry_prod;
    logic              entry_valid;
    logic [LEN_W-1:0]  len_eff;
    logic              overflow;
    logic              slot_free;

    logic              tbl_we;
    logic [TBL_AW-1:0] tbl_waddr;
    logic [PROD_W:0]   tbl_wdata;
    logic [BODY_AW-1:0] body_waddr;
    logic [LEN_W-1:0]  len_wdata;
    logic              body_re;
    logic [BODY_AW-1:0] body_raddr;
    logic              stk_we;
    logic [STK_AW-1:0] stk_waddr;
    logic [SYM_W-1:0]  stk_wdata;
    logic [SYM_W-1:0]  sym_out;

    assign prod_ok     = int'(prod_reg) < PRODUCTIONS;
    assign pos_ok      = int'(pos_reg) < MAX_BODY;
    assign entry_prod  = tbl_rdata_reg[PROD_W-1:0];
    assign entry_valid = tbl_rdata_reg[PROD_W];
    assign slot_free   = !out_valid_reg || out_ready;

    // A one-symbol body holding the lambda mark is empty
    assign len_eff = (len_rdata_reg == LEN_W'(1) && body_rdata_reg == LAMBDA_MARK)
                     ? '0 : len_rdata_reg;
    assign overflow = (int'(sp_reg) - 1 + int'(len_eff)) > STACK_DEPTH;

    // Table write port: clearing pass or load item
    always_comb
    begin
        tbl_we    = cmd.clr_step || cmd.tbl_wr;
        tbl_waddr = {nt_reg, t_reg};
        tbl_wdata = '0;
        if (cmd.clr_step)
        begin
            tbl_waddr = clr_reg;
        end
        else if (prod_ok)
        begin
            tbl_wdata = {1'b1, PROD_W'(prod_reg)};
        end
    end

    assign body_waddr = BODY_AW'(int'(prod_reg) * MAX_BODY + int'(pos_reg));
    assign len_wdata  = (int'(pos_reg) > MAX_BODY) ? LEN_W'(MAX_BODY) : LEN_W'(pos_reg);

    // Body read port: first symbol for the lambda test, then the body top down
    always_comb
    begin
        body_re    = 1'b0;
        body_raddr = BODY_AW'(int'(entry_prod) * MAX_BODY);
        if (cmd.entry_rd)
        begin
            body_re = 1'b1;
        end
        else if (cmd.pop_setup && len_eff != '0)
        begin
            body_re    = 1'b1;
            body_raddr = BODY_AW'(int'(entry_prod) * MAX_BODY + int'(len_eff) - 1);
        end
        else if (cmd.push && cnt_reg > LEN_W'(1))
        begin
            body_re    = 1'b1;
            body_raddr = BODY_AW'(int'(entry_prod) * MAX_BODY + int'(cnt_reg) - 2);
        end
    end

    // Stack write port
    always_comb
    begin
        stk_we    = cmd.begin_base || cmd.begin_top || cmd.push;
        stk_waddr = STK_AW'(sp_reg);
        stk_wdata = body_rdata_reg;
        if (cmd.begin_base)
        begin
            stk_waddr = '0;
            stk_wdata = END_MARK;
        end
        else if (cmd.begin_top)
        begin
            stk_waddr = STK_AW'(1);
            stk_wdata = start_reg;
        end
    end

    always_comb
    begin
        sp_next = sp_reg;
        if (cmd.begin_top)
        begin
            sp_next = SP_W'(2);
        end
        else if (cmd.pop_match || cmd.pop_setup)
        begin
            sp_next = sp_reg - SP_W'(1);
        end
        else if (cmd.push)
        begin
            sp_next = sp_reg + SP_W'(1);
        end
    end

    always_comb
    begin
        case (cmd.sym_sel)
            SSEL_TOP:   sym_out = stk_rdata_reg;
            SSEL_START: sym_out = start_reg;
            default:    sym_out = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            tbl_mem[tbl_waddr] <= tbl_wdata;
        end
        if (cmd.tbl_rd)
        begin
            tbl_rdata_reg <= tbl_mem[{stk_rdata_reg, sym_reg}];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.body_wr && prod_ok && pos_ok)
        begin
            body_mem[body_waddr] <= sym_reg;
        end
        if (body_re)
        begin
            body_rdata_reg <= body_mem[body_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.len_wr && prod_ok)
        begin
            len_mem[PROD_W'(prod_reg)] <= len_wdata;
        end
        if (cmd.entry_rd)
        begin
            len_rdata_reg <= len_mem[entry_prod];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk_mem[stk_waddr] <= stk_wdata;
        end
        if (cmd.stk_rd)
        begin
            stk_rdata_reg <= stk_mem[STK_AW'(sp_reg - SP_W'(1))];
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            op_reg   <= in_operation;
            nt_reg   <= in_nonterminal;
            t_reg    <= in_terminal;
            prod_reg <= in_production;
            pos_reg  <= in_position;
            sym_reg  <= in_symbol;
        end
        if (cmd.pop_setup)
        begin
            cnt_reg <= len_eff;
        end
        else if (cmd.push)
        begin
            cnt_reg <= cnt_reg - LEN_W'(1);
        end
        if (cmd.emit)
        begin
            out_act_reg  <= cmd.act;
            out_prod_reg <= cmd.prod_sel ? PROD_FIELD_W'(entry_prod) : '0;
            out_sym_reg  <= sym_out;
            out_last_reg <= cmd.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg     <= START_RESET;
            sp_reg        <= '0;
            active_reg    <= 1'b0;
            steps_reg     <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                start_reg <= cfg_wr_data;
            end
            sp_reg <= sp_next;
            if (cmd.begin_top)
            begin
                active_reg <= 1'b1;
            end
            else if (cmd.deactivate)
            begin
                active_reg <= 1'b0;
            end
            if (cmd.tok_start)
            begin
                steps_reg <= '0;
            end
            else if (cmd.step_inc)
            begin
                steps_reg <= steps_reg + STEP_W'(1);
            end
            if (cmd.clr_step)
            begin
                clr_reg <= clr_reg + TBL_AW'(1);
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        status.clr_last    = &clr_reg;
        status.op          = op_t'(op_reg);
        status.active      = active_reg;
        status.sp_zero     = sp_reg == '0;
        status.top_eq_tok  = stk_rdata_reg == sym_reg;
        status.tok_is_end  = sym_reg == END_MARK;
        status.entry_valid = entry_valid;
        status.steps_max   = int'(steps_reg) >= MAX_STEPS;
        status.overflow    = overflow;
        status.len_zero    = len_eff == '0;
        status.cnt_last    = cnt_reg == LEN_W'(1);
        status.slot_free   = slot_free;
    end

    assign out_valid           = out_valid_reg;
    assign out_action          = out_act_reg;
    assign out_production_used = out_prod_reg;
    assign out_stack_symbol    = out_sym_reg;
    assign out_last            = out_last_reg;

endmodule

// ===== hw/rtl/ll1pp_ctrl.sv =====
module ll1pp_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  ll1pp_pkg::dp_status_t status,
    output ll1pp_pkg::dp_cmd_t    cmd
);
    import ll1pp_pkg::*;

    typedef enum logic [9:0] {
        S_CLEAR    = 10'b00_0000_0001,
        S_IDLE     = 10'b00_0000_0010,
        S_DISPATCH = 10'b00_0000_0100,
        S_BEGIN    = 10'b00_0000_1000,
        S_READ     = 10'b00_0001_0000,
        S_TOP      = 10'b00_0010_0000,
        S_LOOK     = 10'b00_0100_0000,
        S_LEN      = 10'b00_1000_0000,
        S_PUSH     = 10'b01_0000_0000,
        S_EXPAND   = 10'b10_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.act    = ACT_ACK;
        cmd.sym_sel = SSEL_ZERO;
        in_ready   = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (status.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                unique case (status.op) inside
                    OP_TABLE, OP_BODY, OP_LENGTH:
                    begin
                        if (status.slot_free)
                        begin
                            cmd.tbl_wr  = status.op == OP_TABLE;
                            cmd.body_wr = status.op == OP_BODY;
                            cmd.len_wr  = status.op == OP_LENGTH;
                            cmd.emit    = 1'b1;
                            state_next  = S_IDLE;
                        end
                    end
                    OP_BEGIN:
                    begin
                        cmd.begin_base = 1'b1;
                        state_next     = S_BEGIN;
                    end
                    OP_TOKEN:
                    begin
                        if (status.active)
                        begin
                            cmd.tok_start = 1'b1;
                            state_next    = S_READ;
                        end
                        else if (status.slot_free)
                        begin
                            cmd.emit   = 1'b1;
                            cmd.act    = ACT_REJECT;
                            state_next = S_IDLE;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_BEGIN:
            begin
                if (status.slot_free)
                begin
                    cmd.begin_top = 1'b1;
                    cmd.emit      = 1'b1;
                    cmd.sym_sel   = SSEL_START;
                    state_next    = S_IDLE;
                end
            end
            S_READ:
            begin
                if (!status.sp_zero)
                begin
                    cmd.stk_rd = 1'b1;
                    state_next = S_TOP;
                end
                else if (status.slot_free)
                begin
                    cmd.emit       = 1'b1;
                    cmd.act        = ACT_REJECT;
                    cmd.deactivate = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_TOP:
            begin
                if (!status.top_eq_tok)
                begin
                    cmd.tbl_rd = 1'b1;
                    state_next = S_LOOK;
                end
                else if (status.slot_free)
                begin
                    cmd.emit    = 1'b1;
                    cmd.sym_sel = SSEL_TOP;
                    state_next  = S_IDLE;
                    if (status.tok_is_end)
                    begin
                        cmd.act        = ACT_ACCEPT;
                        cmd.deactivate = 1'b1;
                    end
                    else
                    begin
                        cmd.act       = ACT_MATCH;
                        cmd.pop_match = 1'b1;
                    end
                end
            end
            S_LOOK:
            begin
                if (status.entry_valid && !status.steps_max)
                begin
                    cmd.entry_rd = 1'b1;
                    state_next   = S_LEN;
                end
                else if (status.slot_free)
                begin
                    cmd.emit       = 1'b1;
                    cmd.act        = ACT_REJECT;
                    cmd.sym_sel    = SSEL_TOP;
                    cmd.deactivate = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_LEN:
            begin
                if (!status.overflow)
                begin
                    cmd.pop_setup = 1'b1;
                    state_next    = status.len_zero ? S_EXPAND : S_PUSH;
                end
                else if (status.slot_free)
                begin
                    cmd.emit       = 1'b1;
                    cmd.act        = ACT_REJECT;
                    cmd.sym_sel    = SSEL_TOP;
                    cmd.deactivate = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_PUSH:
            begin
                cmd.push = 1'b1;
                if (status.cnt_last)
                begin
                    state_next = S_EXPAND;
                end
            end
            S_EXPAND:
            begin
                if (status.slot_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.act      = ACT_EXPAND;
                    cmd.sym_sel  = SSEL_TOP;
                    cmd.prod_sel = 1'b1;
                    cmd.step_inc = 1'b1;
                    state_next   = S_READ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // every action but an expansion closes the item
        cmd.last = cmd.act != ACT_EXPAND;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hw/rtl/ll1_predictive_parse_engine.sv =====
// Channel   Direction  Handshake      Payload
// items     in         valid/ready    operation, nonterminal, terminal, production,
//                                     position, symbol
// results   out        valid/ready    action, production_used, stack_symbol, last
// cfg       in         cfg_wr_en      cfg_wr_data (start symbol)
//
// A token reads the stack top before a match or accept; each expansion adds a table
// read, a length read, a pop and one push per body symbol: the stack, table and body
// memories each have one registered read port and every step waits on one.
// After reset the parse table is cleared one entry a cycle, all 16384 entries, with
// items.ready low; configuration writes are taken during that pass.
// A stalled results channel holds the engine in the state that wants to emit.
module ll1_predictive_parse_engine (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [ll1pp_pkg::SYM_W-1:0] cfg_wr_data,
    ll1pp_item_if.sink                 items,
    ll1pp_result_if.source             results
);
    import ll1pp_pkg::*;

    // command and status between the sequencer and the datapath
    dp_cmd_t    cmd;
    dp_status_t status;
    logic       in_ready;

    // Sequencer: one item at a time, steps the token loop
    ll1pp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (items.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath: parse table, bodies, symbol stack and the output register
    ll1pp_datapath u_datapath (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_wr_data         (cfg_wr_data),
        .in_operation        (items.operation),
        .in_nonterminal      (items.nonterminal),
        .in_terminal         (items.terminal),
        .in_production       (items.production),
        .in_position         (items.position),
        .in_symbol           (items.symbol),
        .cmd                 (cmd),
        .status              (status),
        .out_valid           (results.valid),
        .out_ready           (results.ready),
        .out_action          (results.action),
        .out_production_used (results.production_used),
        .out_stack_symbol    (results.stack_symbol),
        .out_last            (results.last)
    );

    // an input transfer happens only in the idle state
    assign items.ready = in_ready;

endmodule

// ===== hw/rtl/ll1pp_checker.sv =====
module ll1pp_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic [ll1pp_pkg::ACT_W-1:0]        action,
    input logic [ll1pp_pkg::PROD_FIELD_W-1:0] production_used,
    input logic [ll1pp_pkg::SYM_W-1:0]        stack_symbol,
    input logic                              last
);
    import ll1pp_pkg::*;

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            out_valid && $stable(action) && $stable(stack_symbol) && $stable(last))
        else $error("stalled result changed");

    // only expansions leave an item open
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last == (action != ACT_EXPAND)))
        else $error("last flag does not match action");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && action != ACT_EXPAND |-> production_used == '0)
        else $error("production reported on a non-expand result");

    // one item at a time: ready drops after an input transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item taken while one is in flight");

endmodule

bind ll1_predictive_parse_engine ll1pp_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (items.valid),
    .in_ready        (items.ready),
    .out_valid       (results.valid),
    .out_ready       (results.ready),
    .action          (results.action),
    .production_used (results.production_used),
    .stack_symbol    (results.stack_symbol),
    .last            (results.last)
);
